@@ sv/gfe_pkg.sv @@
// ----------------------------------------------------------------------------
// gfe_pkg
// Shared types for the forward elimination core.
// ----------------------------------------------------------------------------
`default_nettype none
package gfe_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_WT,
    ST_DIV_RD,
    ST_DIV_WT,
    ST_DIV,
    ST_MUL_RD,
    ST_MUL_WT,
    ST_MUL,
    ST_SUB,
    ST_WR,
    ST_OUT_RD,
    ST_OUT_WT,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

@@ sv/gfe_ram.sv @@
// ----------------------------------------------------------------------------
// gfe_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module gfe_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

@@ sv/gfe_div.sv @@
// ----------------------------------------------------------------------------
// gfe_div
// Serial signed fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
`default_nettype none
module gfe_div #(
  parameter int FracBits = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o,
  output logic                    sat_o
);

  localparam int NumW = 32 + FracBits;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [33:0]     trial;
  logic [32:0]     rem_sh;
  logic [NumW:0]   sq;

  // restoring division on magnitudes
  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    rem_sh = {rem_q[31:0], num_q[NumW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_q};
    if (start_i) begin
      num_d  = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), {FracBits{1'b0}}};
      den_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d  = num_i[31] ^ den_i[31];
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // apply sign and clamp
  assign done_o = done_q;
  assign sq     = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
  always_comb begin
    sat_o = 1'b0;
    quo_o = sq[31:0];
    if (!neg_q && quo_q > NumW'(32'h7fffffff)) begin
      sat_o = 1'b1;
      quo_o = 32'h7fffffff;
    end else if (neg_q && quo_q > NumW'(33'h80000000)) begin
      sat_o = 1'b1;
      quo_o = 32'h80000000;
    end
  end

endmodule
`default_nettype wire

@@ sv/gaussian_forward_elimination_core.sv @@
// ----------------------------------------------------------------------------
// gaussian_forward_elimination_core
// Forward Gaussian elimination without pivoting on signed fixed point.
// ----------------------------------------------------------------------------
// Usage: elements of an N x N matrix enter row-major on s_axis (tdata =
// element_value). N comes from cfg_wdata_i when cfg_we_i is high; a write
// drops a partly loaded matrix. Loading accepts one element per cycle. After
// the last element the core eliminates in place: each pivot is read from the
// RAM, each a[i][k] is read and divided by the pivot in the serial divider
// (skipped on a zero pivot, giving a multiplier of zero), and each update j>k
// goes through the shared multiplier and RAM port: read a[k][j], multiply,
// read a[i][j], subtract with saturation and write back. The matrix then
// leaves on m_axis; each element is read from the RAM before it is offered,
// so tvalid drops between elements. tlast marks the final one and tuser
// carries the pivot/saturation flags.
// s_axis_tready is low from the last element until the last result is taken.
// A stalled receiver holds the output register; nothing is lost.
// Reset sets N to MAX_DIM and clears the load count; the RAM is not cleared.
`default_nettype none
module gaussian_forward_elimination_core #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] element_value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] result_value
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser    // [0] zero_pivot_seen, [1] saturated
);

  localparam int DimW  = $clog2(MAX_DIM + 1);
  localparam int IdxW  = $clog2(MAX_DIM);
  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  gfe_pkg::state_e state_q, state_d;

  logic [3:0]      size_q;
  logic [DimW-1:0] n;
  logic [CntW-1:0] total;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic signed [31:0] piv_q, piv_d, m_q, m_d, akj_q, akj_d, res_q, res_d;
  logic signed [63:0] prod_q, prod_d;
  logic            fz_q, fz_d, fs_q, fs_d;
  logic            ov_q, ov_d;
  logic            last_q, last_d;

  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0]     ram_wdata, ram_rdata;
  logic signed [31:0] ram_rdata_s;
  logic            div_start, div_done, div_sat;
  logic signed [31:0] div_quo;
  logic signed [63:0] shifted;
  logic signed [31:0] p_sat;
  logic            p_ov;
  logic signed [32:0] diff;

  // clamp the configured dimension
  always_comb begin
    if (size_q == 4'd0) begin
      n = DimW'(1);
    end else if (32'(size_q) > MAX_DIM) begin
      n = DimW'(MAX_DIM);
    end else begin
      n = DimW'(size_q);
    end
  end
  assign total = CntW'(n) * CntW'(n);

  // row-major address of (r, c)
  function automatic logic [AddrW-1:0] addr_of(input logic [IdxW-1:0] r,
                                               input logic [IdxW-1:0] c,
                                               input logic [DimW-1:0] nn);
    logic [2*DimW-1:0] a;
    a = (2*DimW)'(r) * (2*DimW)'(nn) + (2*DimW)'(c);
    return a[AddrW-1:0];
  endfunction

  gfe_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  gfe_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ram_rdata),
    .den_i   (piv_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  // scale and saturate the registered product
  assign shifted = prod_q >>> FRAC_BITS;
  always_comb begin
    p_ov  = 1'b0;
    p_sat = shifted[31:0];
    if (shifted > 64'sh7fffffff) begin
      p_ov = 1'b1; p_sat = 32'sh7fffffff;
    end else if (shifted < -64'sh80000000) begin
      p_ov = 1'b1; p_sat = 32'sh80000000;
    end
  end
  assign ram_rdata_s = ram_rdata;
  assign diff = 33'(ram_rdata_s) - 33'(p_sat);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfe_pkg::ST_LOAD:
        if (s_axis_tvalid && !cfg_we_i && cnt_q + 1'b1 >= total) begin
          state_d = gfe_pkg::ST_PIV_RD;
        end
      gfe_pkg::ST_PIV_RD: state_d = gfe_pkg::ST_PIV_WT;
      gfe_pkg::ST_PIV_WT: state_d = gfe_pkg::ST_DIV_RD;
      gfe_pkg::ST_DIV_RD: begin
        if (DimW'(k_q) + 1'b1 >= n) begin
          state_d = gfe_pkg::ST_OUT_RD;
        end else begin
          state_d = gfe_pkg::ST_DIV_WT;
        end
      end
      gfe_pkg::ST_DIV_WT: state_d = gfe_pkg::ST_DIV;
      gfe_pkg::ST_DIV:
        if (piv_q == '0 || div_done) begin
          state_d = gfe_pkg::ST_MUL_RD;
        end
      gfe_pkg::ST_MUL_RD: state_d = gfe_pkg::ST_MUL_WT;
      gfe_pkg::ST_MUL_WT: state_d = gfe_pkg::ST_MUL;
      gfe_pkg::ST_MUL:    state_d = gfe_pkg::ST_SUB;
      gfe_pkg::ST_SUB:    state_d = gfe_pkg::ST_WR;
      gfe_pkg::ST_WR: begin
        if (DimW'(j_q) + 1'b1 < n) begin
          state_d = gfe_pkg::ST_MUL_RD;
        end else if (DimW'(i_q) + 1'b1 < n) begin
          state_d = gfe_pkg::ST_DIV_RD;
        end else begin
          state_d = gfe_pkg::ST_PIV_RD;
        end
      end
      gfe_pkg::ST_OUT_RD: state_d = gfe_pkg::ST_OUT_WT;
      gfe_pkg::ST_OUT_WT: state_d = gfe_pkg::ST_OUT;
      gfe_pkg::ST_OUT:
        if (m_axis_tready) begin
          state_d = last_q ? gfe_pkg::ST_LOAD : gfe_pkg::ST_OUT_RD;
        end
      default: state_d = gfe_pkg::ST_LOAD;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_d = cnt_q; k_d = k_q; i_d = i_q; j_d = j_q;
    piv_d = piv_q; m_d = m_q; akj_d = akj_q; res_d = res_q;
    prod_d = prod_q; fz_d = fz_q; fs_d = fs_q; ov_d = ov_q; last_d = last_q;
    ram_we = 1'b0; ram_addr = '0; ram_wdata = s_axis_tdata;
    div_start = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      gfe_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        ram_addr = cnt_q[AddrW-1:0];
        if (s_axis_tvalid) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q + 1'b1 >= total) begin
            cnt_d = '0; k_d = '0; fz_d = 1'b0; fs_d = 1'b0;
          end
        end
      end
      gfe_pkg::ST_PIV_RD: ram_addr = addr_of(k_q, k_q, n);
      gfe_pkg::ST_PIV_WT: begin
        piv_d = ram_rdata;
        i_d   = k_q + 1'b1;
      end
      gfe_pkg::ST_DIV_RD: begin
        ram_addr = addr_of(i_q, k_q, n);
        j_d = k_q + 1'b1;
        if (DimW'(k_q) + 1'b1 >= n) begin
          cnt_d = '0;
        end
      end
      gfe_pkg::ST_DIV_WT: begin
        div_start = piv_q != '0;
        if (piv_q == '0) begin
          fz_d = 1'b1;
        end
      end
      gfe_pkg::ST_DIV: begin
        m_d = '0;
        if (piv_q != '0 && div_done) begin
          m_d  = div_quo;
          fs_d = fs_q | div_sat;
        end
      end
      gfe_pkg::ST_MUL_RD: ram_addr = addr_of(k_q, j_q, n);
      gfe_pkg::ST_MUL_WT: akj_d = ram_rdata;
      gfe_pkg::ST_MUL: begin
        prod_d = 64'(akj_q) * 64'(m_q);
        ram_addr = addr_of(i_q, j_q, n);
      end
      gfe_pkg::ST_SUB: begin
        ram_addr = addr_of(i_q, j_q, n);
        ov_d = p_ov;
        if (diff > 33'sh7fffffff) begin
          res_d = 32'sh7fffffff; ov_d = 1'b1;
        end else if (diff < -33'sh80000000) begin
          res_d = 32'sh80000000; ov_d = 1'b1;
        end else begin
          res_d = diff[31:0];
        end
      end
      gfe_pkg::ST_WR: begin
        ram_we = 1'b1;
        ram_addr = addr_of(i_q, j_q, n);
        ram_wdata = res_q;
        fs_d = fs_q | ov_q;
        if (DimW'(j_q) + 1'b1 < n) begin
          j_d = j_q + 1'b1;
        end else if (DimW'(i_q) + 1'b1 < n) begin
          i_d = i_q + 1'b1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      gfe_pkg::ST_OUT_RD: ram_addr = cnt_q[AddrW-1:0];
      gfe_pkg::ST_OUT_WT: begin
        res_d  = ram_rdata;
        last_d = cnt_q + 1'b1 >= total;
      end
      gfe_pkg::ST_OUT:
        if (m_axis_tready) begin
          cnt_d = last_q ? '0 : cnt_q + 1'b1;
        end
      default: ;
    endcase
    if (cfg_we_i && state_q == gfe_pkg::ST_LOAD) begin
      cnt_d = '0;
    end
  end

  // outputs
  assign m_axis_tvalid = state_q == gfe_pkg::ST_OUT;
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = {fs_q, fz_q};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfe_pkg::ST_LOAD;
      size_q  <= 4'(MAX_DIM);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q <= k_d; i_q <= i_d; j_q <= j_d;
    piv_q <= piv_d; m_q <= m_d; akj_q <= akj_d; res_q <= res_d;
    prod_q <= prod_d; fz_q <= fz_d; fs_q <= fs_d; ov_q <= ov_d;
    last_q <= last_d;
  end

endmodule
`default_nettype wire
